/* hdl/lcar_pkg.sv */
package lcar_pkg;

    localparam int TIMEOUT_W = 24;
    localparam int COUNT_W   = 8;
    localparam int GAIN_W    = 32;
    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_ADDR_W = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    localparam logic [IN_TUSER_W-1:0] MODE_TARE    = 2'd1;
    localparam logic [IN_TUSER_W-1:0] MODE_MEASURE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN    = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd100000;
    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 8'd1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 32'h0001_0000;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic             start;
        logic             tare;
        logic [SUM_W-1:0] sum;
    } t_calc_req;

    typedef struct packed {
        logic               busy;
        logic [VALUE_W-1:0] value;
    } t_calc_rsp;

endpackage

/* hdl/lcar_calc.sv */
module lcar_calc #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcar_pkg::t_calc_req             i_req,
    input  logic [lcar_pkg::COUNT_W-1:0]    i_num,
    input  logic [lcar_pkg::GAIN_W-1:0]     i_gain,
    output lcar_pkg::t_calc_rsp             o_rsp
);
    import lcar_pkg::*;

    // offset times count, signed difference, product, and dividend widths
    localparam int OW = SAMPLE_BITS + COUNT_W + 1;
    localparam int DW = ((OW > SUM_W + 1) ? OW : SUM_W + 1) + 1;
    localparam int PW = DW + GAIN_W;
    localparam int QW = PW - 8;
    localparam int CW = $clog2(QW + 1);

    typedef enum logic [6:0] {
        C_IDLE  = 7'b0000001,
        C_PROD  = 7'b0000010,
        C_DIFF  = 7'b0000100,
        C_MUL   = 7'b0001000,
        C_ROUND = 7'b0010000,
        C_DIV   = 7'b0100000,
        C_DONE  = 7'b1000000
    } t_cstate;

    t_cstate                 r_state;
    logic [CW-1:0]           r_cnt;
    logic                    r_tare;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_sum;
    logic [SAMPLE_BITS-1:0]  r_offset;
    logic signed [OW-1:0]    r_prod;
    logic [DW-1:0]           r_m;
    logic [DW:0]             r_hi;
    logic [GAIN_W-1:0]       r_lo;
    logic [QW-1:0]           r_dq;
    logic [COUNT_W-1:0]      r_rem;
    logic [VALUE_W-1:0]      r_value;

    logic signed [OW-1:0]    w_prod;
    logic signed [DW-1:0]    w_diff;
    logic [DW-1:0]           w_mag;
    logic [GAIN_W-1:0]       w_gmag;
    logic [SUM_W-1:0]        w_smag;
    logic [DW:0]             w_add;
    logic [PW-1:0]           w_p;
    logic [COUNT_W:0]        w_trial;
    logic                    w_ge;
    logic [SUM_W-1:0]        w_avg;
    logic                    w_ovf;
    logic [VALUE_W-1:0]      w_meas;

    always_comb begin
        w_prod  = $signed({1'b0, i_num}) * $signed(r_offset);
        w_diff  = DW'($signed(r_sum)) - DW'(r_prod);
        w_mag   = w_diff[DW-1] ? (DW'(0) - w_diff) : w_diff;
        w_gmag  = i_gain[GAIN_W-1] ? (GAIN_W'(0) - i_gain) : i_gain;
        w_smag  = i_req.sum[SUM_W-1] ? (SUM_W'(0) - i_req.sum) : i_req.sum;
        w_add   = r_hi + (r_lo[0] ? {1'b0, r_m} : '0);
        w_p     = {r_hi[DW-1:0], r_lo};
        w_trial = {r_rem, r_dq[QW-1]};
        w_ge    = (w_trial >= {1'b0, i_num});
        w_avg   = r_neg ? (SUM_W'(0) - r_dq[SUM_W-1:0]) : r_dq[SUM_W-1:0];
        w_ovf   = |r_dq[QW-1:VALUE_W-1];
        if (r_neg) begin
            w_meas = w_ovf ? VALUE_MIN : (VALUE_W'(0) - r_dq[VALUE_W-1:0]);
        end else begin
            w_meas = w_ovf ? VALUE_MAX : r_dq[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_offset <= '0;
            r_value  <= '0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_tare <= i_req.tare;
                        r_sum  <= i_req.sum;
                        if (i_req.tare) begin
                            // divide the sum magnitude by the count, sign restored at the end
                            r_neg   <= i_req.sum[SUM_W-1];
                            r_dq    <= QW'(w_smag);
                            r_rem   <= '0;
                            r_cnt   <= CW'(QW);
                            r_state <= C_DIV;
                        end else begin
                            r_state <= C_PROD;
                        end
                    end
                end
                C_PROD: begin
                    r_prod  <= w_prod;
                    r_state <= C_DIFF;
                end
                C_DIFF: begin
                    r_m     <= w_mag;
                    r_neg   <= w_diff[DW-1] ^ i_gain[GAIN_W-1];
                    r_hi    <= '0;
                    r_lo    <= w_gmag;
                    r_cnt   <= CW'(GAIN_W);
                    r_state <= C_MUL;
                end
                C_MUL: begin
                    // shift-add, one gain bit per cycle, LSB first
                    r_hi  <= {1'b0, w_add[DW:1]};
                    r_lo  <= {w_add[0], r_lo[GAIN_W-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    // floor of a negative quotient: round the magnitude up
                    r_dq    <= w_p[PW-1:8] + QW'(r_neg && (w_p[7:0] != 8'd0));
                    r_rem   <= '0;
                    r_cnt   <= CW'(QW);
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    r_rem <= w_ge ? COUNT_W'(w_trial - {1'b0, i_num}) : w_trial[COUNT_W-1:0];
                    r_dq  <= {r_dq[QW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= C_DONE;
                    end
                end
                C_DONE: begin
                    if (r_tare) begin
                        r_offset <= w_avg[SAMPLE_BITS-1:0];
                        r_value  <= VALUE_W'($signed(w_avg[SAMPLE_BITS-1:0]));
                    end else begin
                        r_value  <= w_meas;
                    end
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy  = (r_state != C_IDLE);
    assign o_rsp.value = r_value;

endmodule

/* hdl/load_cell_adc_reader.sv */
// Load cell ADC reader: reads a 24-bit two-wire bridge converter.
// Every input beat is one tick, a half period of the serial clock. tuser
// carries the command (plain tick, start tare, start measure), tdata[0] the
// data pin level. Every input beat gives exactly one output beat with the
// serial clock level for that tick, the busy flag and, on the tick an
// operation ends, done, timed_out, was_tare and the value.
// A tare stores the truncated sample average as offset; a measure returns
// ((sum - count*offset) * gain >> 8) / count saturated to signed Q.8.
// The user writes configuration (timeout, sample count, gain) through the
// plain write port while no operation runs; the block does not enforce it.
// Latency: an ordinary tick's result beat is valid the cycle after the
// input beat; one item a cycle when the receiver keeps up. The tick that ends
// the last sample runs the arithmetic unit: a bit-serial 32-step multiply and
// a one-bit-per-cycle divide of SAMPLE_BITS+34 steps, the multiply skipped
// for a tare; no input is taken meanwhile.
// Reset (synchronous, active low) returns to idle, clears the offset and
// loads the register defaults. A stalled receiver holds the output beat and
// the block then takes no input.
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lcar_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [lcar_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lcar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] dout, zero pad
    input  logic [lcar_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // [1:0] mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] sck, [1] busy_res, [2] done_res, [3] timed_out, [35:4] value, zero pad
    output logic [lcar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [lcar_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // [0] was_tare
);
    import lcar_pkg::*;

    localparam int BW = $clog2(SAMPLE_BITS + 1);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_WAIT  = 6'b000010,
        PH_HIGH  = 6'b000100,
        PH_LOW   = 6'b001000,
        PH_XHIGH = 6'b010000,
        PH_XLOW  = 6'b100000
    } t_phase;

    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [COUNT_W-1:0]     r_count;
    logic [GAIN_W-1:0]      r_gain;

    t_phase                 r_phase, n_phase;
    logic [BW-1:0]          r_bit, n_bit;
    logic [SAMPLE_BITS-1:0] r_shift, n_shift;
    logic [TIMEOUT_W-1:0]   r_wait, n_wait;
    logic [COUNT_W-1:0]     r_idx, n_idx;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_tare, n_tare;
    logic                   r_calc;

    logic                   r_out_valid;
    logic                   r_o_sck, r_o_busy, r_o_done, r_o_tmo, r_o_wtare;
    logic [VALUE_W-1:0]     r_o_value;

    logic                   w_sck, w_done, w_tmo, w_final;
    logic [COUNT_W-1:0]     w_num;
    logic                   w_out_free, w_accept, w_calc_ret;
    logic                   w_dout;
    logic [IN_TUSER_W-1:0]  w_mode;
    t_calc_req              w_req;
    t_calc_rsp              w_rsp;

    assign w_dout     = s_axis_tdata[0];
    assign w_mode     = s_axis_tuser;
    assign w_num      = (r_count == '0) ? COUNT_W'(1) : r_count;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_out_free && !r_calc;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_calc_ret = r_calc && !w_rsp.busy && w_out_free;

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_wait  = r_wait;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_tare  = r_tare;
        w_sck   = 1'b0;
        w_done  = 1'b0;
        w_tmo   = 1'b0;
        w_final = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (w_mode == MODE_TARE || w_mode == MODE_MEASURE) begin
                    n_tare  = (w_mode == MODE_TARE);
                    n_idx   = '0;
                    n_sum   = '0;
                    n_wait  = '0;
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!w_dout) begin
                    n_shift = '0;
                    n_bit   = '0;
                    n_phase = PH_HIGH;
                end else begin
                    n_wait = r_wait + 1'b1;
                    if (n_wait >= r_timeout) begin
                        w_done  = 1'b1;
                        w_tmo   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_HIGH: begin
                w_sck   = 1'b1;
                n_shift = {r_shift[SAMPLE_BITS-2:0], w_dout};
                n_bit   = r_bit + 1'b1;
                n_phase = PH_LOW;
            end
            PH_LOW: begin
                n_phase = (r_bit >= BW'(SAMPLE_BITS)) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
                w_sck   = 1'b1;
                n_phase = PH_XLOW;
            end
            PH_XLOW: begin
                n_sum = r_sum + SUM_W'($signed(r_shift));
                n_idx = r_idx + 1'b1;
                if (n_idx >= w_num) begin
                    // last sample: hand the sum to the arithmetic unit
                    w_final = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_wait  = '0;
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign w_req.start = w_accept && w_final;
    assign w_req.tare  = r_tare;
    assign w_req.sum   = n_sum;

    lcar_calc #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (w_num),
        .i_gain  (r_gain),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_count   <= COUNT_RESET;
            r_gain    <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_COUNT:   r_count   <= i_cfg_wdata[COUNT_W-1:0];
                CFG_GAIN:    r_gain    <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_wait  <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_tare  <= 1'b0;
            r_calc  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_wait  <= n_wait;
                r_idx   <= n_idx;
                r_sum   <= n_sum;
                r_tare  <= n_tare;
            end
            if (w_req.start) begin
                r_calc <= 1'b1;
            end else if (w_calc_ret) begin
                r_calc <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && !w_final) || w_calc_ret) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_calc_ret) begin
            r_o_sck   <= 1'b0;
            r_o_busy  <= 1'b0;
            r_o_done  <= 1'b1;
            r_o_tmo   <= 1'b0;
            r_o_wtare <= r_tare;
            r_o_value <= w_rsp.value;
        end else if (w_accept && !w_final) begin
            r_o_sck   <= w_sck;
            r_o_busy  <= (n_phase != PH_IDLE);
            r_o_done  <= w_done;
            r_o_tmo   <= w_tmo;
            r_o_wtare <= w_done && r_tare;
            r_o_value <= '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - 4)'(0), r_o_value,
                            r_o_tmo, r_o_done, r_o_busy, r_o_sck};
    assign m_axis_tuser  = r_o_wtare;

endmodule

/* verif/lcar_checker.sv */
`timescale 1ns / 1ps

module lcar_checker
    import lcar_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,   // [0] dout
    input  logic [IN_TUSER_W-1:0]  i_in_user,   // [1:0] mode
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,  // [0] sck, [1] busy, [2] done, [3] timed_out,
                                                // [35:4] value
    input  logic [OUT_TUSER_W-1:0] i_out_user,  // [0] was_tare
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_done_count,
    output int                     o_timeout_count
);

    localparam int SAMPLE_W = 24;
    localparam logic signed [95:0] Q8_TOP    = 96'sh7FFF_FFFF;
    localparam logic signed [95:0] Q8_BOTTOM = -96'sh8000_0000;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_WAIT,
        RD_BIT_HIGH,
        RD_BIT_LOW,
        RD_PULSE_HIGH,
        RD_PULSE_LOW
    } t_rd_state;

    typedef struct packed {
        logic               sck;
        logic               busy;
        logic               done;
        logic               timed_out;
        logic               was_tare;
        logic [VALUE_W-1:0] value;
    } t_tick_out;

    logic [TIMEOUT_W-1:0] timeout_q;
    logic [COUNT_W-1:0]   count_q;
    logic [GAIN_W-1:0]    gain_q;

    t_rd_state            rd_state;
    int                   bits_in;
    logic [SAMPLE_W-1:0]  sample_word;
    logic [TIMEOUT_W-1:0] wait_ticks;
    logic [7:0]           samples_in;
    logic [SUM_W-1:0]     sample_sum;
    logic [SAMPLE_W-1:0]  tare_offset;
    logic                 tare_run;

    t_tick_out awaited_ticks[$];
    int        beats_out;
    int        fails;
    int        dones;
    int        timeouts;

    function automatic int samples_per_op();
        return (count_q == 0) ? 1 : int'(count_q);
    endfunction

    // ((sum - num*offset) * gain) floored by 256, then truncated by num, clamped to Q.8
    function automatic logic [VALUE_W-1:0] scaled_weight();
        logic signed [SUM_W-1:0]    sum_s;
        logic signed [SAMPLE_W-1:0] off_s;
        logic signed [GAIN_W-1:0]   gain_s;
        logic signed [95:0]         net;
        logic signed [95:0]         q;
        int                         num;
        num    = samples_per_op();
        sum_s  = sample_sum;
        off_s  = tare_offset;
        gain_s = gain_q;
        net    = sum_s;
        net    = net - num * off_s;
        q      = (net * gain_s) >>> 8;
        q      = q / num;
        if (q > Q8_TOP)
            return VALUE_MAX;
        if (q < Q8_BOTTOM)
            return VALUE_MIN;
        return q[VALUE_W-1:0];
    endfunction

    task automatic read_tick(input logic [IN_TUSER_W-1:0] mode, input logic dout,
                             output t_tick_out r);
        logic signed [SUM_W-1:0] sum_s;
        int                      avg;
        r = '0;
        case (rd_state)
            RD_IDLE: begin
                if (mode == MODE_TARE || mode == MODE_MEASURE) begin
                    tare_run   = (mode == MODE_TARE);
                    samples_in = '0;
                    sample_sum = '0;
                    wait_ticks = '0;
                    rd_state   = RD_WAIT;
                end
            end
            RD_WAIT: begin
                if (!dout) begin
                    sample_word = '0;
                    bits_in     = 0;
                    rd_state    = RD_BIT_HIGH;
                end else begin
                    wait_ticks = wait_ticks + 1'b1;
                    if (wait_ticks >= timeout_q) begin
                        r.done      = 1'b1;
                        r.timed_out = 1'b1;
                        r.was_tare  = tare_run;
                        rd_state    = RD_IDLE;
                    end
                end
            end
            RD_BIT_HIGH: begin
                r.sck       = 1'b1;
                sample_word = {sample_word[SAMPLE_W-2:0], dout};
                bits_in++;
                rd_state    = RD_BIT_LOW;
            end
            RD_BIT_LOW: begin
                rd_state = (bits_in >= SAMPLE_W) ? RD_PULSE_HIGH : RD_BIT_HIGH;
            end
            RD_PULSE_HIGH: begin
                r.sck    = 1'b1;
                rd_state = RD_PULSE_LOW;
            end
            RD_PULSE_LOW: begin
                sample_sum = sample_sum
                           + {{(SUM_W-SAMPLE_W){sample_word[SAMPLE_W-1]}}, sample_word};
                samples_in = samples_in + 1'b1;
                if (samples_in >= samples_per_op()) begin
                    r.done   = 1'b1;
                    r.was_tare = tare_run;
                    if (tare_run) begin
                        sum_s       = sample_sum;
                        avg         = sum_s / samples_per_op();
                        tare_offset = avg[SAMPLE_W-1:0];
                        r.value     = {{(VALUE_W-SAMPLE_W){tare_offset[SAMPLE_W-1]}}, tare_offset};
                    end else begin
                        r.value = scaled_weight();
                    end
                    rd_state = RD_IDLE;
                end else begin
                    wait_ticks = '0;
                    rd_state   = RD_WAIT;
                end
            end
            default: rd_state = RD_IDLE;
        endcase
        r.busy = (rd_state != RD_IDLE);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            if (fails < 10)
                $display("mismatch on output beat %0d, %s: expected %h, got %h",
                         beats_out, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_tick_out got;
        t_tick_out want;
        if (!i_rst_n) begin
            timeout_q   = TIMEOUT_RESET;
            count_q     = COUNT_RESET;
            gain_q      = GAIN_RESET;
            rd_state    = RD_IDLE;
            bits_in     = 0;
            sample_word = '0;
            wait_ticks  = '0;
            samples_in  = '0;
            sample_sum  = '0;
            tare_offset = '0;
            tare_run    = 1'b0;
            awaited_ticks.delete();
        end else begin
            // retire the oldest prediction first: a result never belongs to this edge's input
            if (i_out_valid && i_out_ready) begin
                got.sck       = i_out_data[0];
                got.busy      = i_out_data[1];
                got.done      = i_out_data[2];
                got.timed_out = i_out_data[3];
                got.value     = i_out_data[35:4];
                got.was_tare  = i_out_user[0];
                if (awaited_ticks.size() == 0) begin
                    if (fails < 10)
                        $display("output beat %0d arrived with no tick awaiting it", beats_out);
                    fails++;
                end else begin
                    want = awaited_ticks.pop_front();
                    check_field("sck", want.sck, got.sck);
                    check_field("busy", want.busy, got.busy);
                    check_field("done", want.done, got.done);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("was_tare", want.was_tare, got.was_tare);
                    check_field("value", want.value, got.value);
                end
                beats_out++;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TIMEOUT: timeout_q = i_cfg_wdata[TIMEOUT_W-1:0];
                    CFG_COUNT:   count_q   = i_cfg_wdata[COUNT_W-1:0];
                    CFG_GAIN:    gain_q    = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                read_tick(i_in_user, i_in_data[0], want);
                awaited_ticks.push_back(want);
                if (want.done)
                    dones++;
                if (want.timed_out)
                    timeouts++;
            end
        end
        o_pending       <= awaited_ticks.size();
        o_fail_count    <= fails;
        o_done_count    <= dones;
        o_timeout_count <= timeouts;
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import lcar_pkg::*;

    localparam logic [IN_TUSER_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [IN_TUSER_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int RANDOM_TICKS = 1050;
    localparam int MIN_OPS      = 8;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = CFG_TIMEOUT;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = MODE_PLAIN;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int pending;
    int done_count;
    int timeout_count;

    int                   cycles        = 0;
    int                   ticks_sent    = 0;
    int                   burst_left    = 0;
    int                   ops_run       = 0;
    int                   configs_used  = 0;
    bit                   stream_on     = 1'b0;
    bit                   quiet         = 1'b0;
    logic [TIMEOUT_W-1:0] timeout_now;
    logic [COUNT_W-1:0]   count_now;
    int                   ready_style   = 0;
    int                   run_left      = 0;
    logic                 ready_run     = 1'b0;

    load_cell_adc_reader i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lcar_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_done_count    (done_count),
        .o_timeout_count (timeout_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("load_cell_adc_reader test failed");
            $finish;
        end
    end

    // receiver: always ready, sparse random stalls, or long on/off runs
    always @(posedge i_clk) begin
        if (cycles % 300 == 0)
            ready_style = $urandom_range(0, 2);
        case (ready_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (run_left == 0) begin
                    run_left  = $urandom_range(1, 8);
                    ready_run = !ready_run;
                end
                run_left--;
                m_axis_tready <= ready_run;
            end
        endcase
    end

    function automatic logic [IN_TUSER_W-1:0] any_mode();
        return IN_TUSER_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [23:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'h00_0000;
            3: return 24'hFF_FFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic [IN_TUSER_W-1:0] mode, input logic dout);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, dout};
        stream_on = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                stream_on = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic stop_stream();
        if (stream_on)
            s_axis_tvalid <= 1'b0;
        stream_on = 1'b0;
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick($urandom_range(0, 1) ? MODE_PLAIN : MODE_SPARE,
                             1'($urandom_range(0, 1)));
    endtask

    // hold off until every result is back, then write all three registers
    task automatic reconfigure(input logic [TIMEOUT_W-1:0] t, input logic [COUNT_W-1:0] c,
                               input logic [GAIN_W-1:0] g);
        stop_stream();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TIMEOUT;
        i_cfg_wdata <= {{(CFG_W-TIMEOUT_W){1'b0}}, t};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_COUNT;
        i_cfg_wdata <= {{(CFG_W-COUNT_W){1'b0}}, c};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_GAIN;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_now = t;
        count_now   = c;
        configs_used++;
    endtask

    // one conversion: a few not-ready ticks, ready, 24 bits MSB first, closing pulse
    task automatic convert(input logic [23:0] word);
        int room;
        room = (timeout_now == 0) ? 0 : ((timeout_now > 4) ? 3 : int'(timeout_now) - 1);
        repeat ($urandom_range(0, room)) send_tick(any_mode(), 1'b1);
        send_tick(any_mode(), 1'b0);
        for (int b = 23; b >= 0; b--) begin
            send_tick(any_mode(), word[b]);
            send_tick(any_mode(), 1'($urandom_range(0, 1)));
        end
        send_tick(any_mode(), 1'($urandom_range(0, 1)));
        send_tick(any_mode(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_op(input logic tare);
        int num;
        int cut;
        num = (count_now == 0) ? 1 : int'(count_now);
        cut = -1;
        ops_run++;
        if (timeout_now <= 40 && $urandom_range(0, 3) == 0)
            cut = $urandom_range(0, num - 1);
        send_tick(tare ? MODE_TARE : MODE_MEASURE, 1'($urandom_range(0, 1)));
        for (int k = 0; k < num; k++) begin
            if (k == cut) begin
                // keep the pin high until the wait budget runs out
                repeat ((timeout_now == 0) ? 1 : int'(timeout_now)) send_tick(any_mode(), 1'b1);
                return;
            end
            convert(pick_word());
        end
    endtask

    initial begin
        logic [TIMEOUT_W-1:0] t;
        logic [COUNT_W-1:0]   c;
        logic [GAIN_W-1:0]    g;
        logic [31:0]          r;
        int                   p;
        int                   first_random;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        timeout_now = TIMEOUT_RESET;
        count_now   = COUNT_RESET;

        // idle ticks, including the unused mode code
        send_tick(MODE_PLAIN, 1'b0);
        send_tick(MODE_PLAIN, 1'b1);
        send_tick(MODE_SPARE, 1'b1);
        send_tick(MODE_SPARE, 1'b0);
        // zero wait budget: first not-ready tick aborts
        reconfigure(24'd0, 8'd1, GAIN_RESET);
        send_tick(MODE_TARE, 1'b1);
        send_tick(MODE_PLAIN, 1'b1);
        send_tick(MODE_MEASURE, 1'b0);
        send_tick(MODE_MEASURE, 1'b1);
        // commands during the wait are ignored; third not-ready tick aborts
        reconfigure(24'd3, 8'd1, GAIN_RESET);
        send_tick(MODE_TARE, 1'b0);
        send_tick(MODE_MEASURE, 1'b1);
        send_tick(MODE_TARE, 1'b1);
        send_tick(MODE_SPARE, 1'b1);
        send_tick(MODE_MEASURE, 1'b1);
        send_tick(MODE_PLAIN, 1'b1);
        send_tick(MODE_TARE, 1'b1);
        send_tick(MODE_MEASURE, 1'b1);

        first_random = ticks_sent;
        p = 0;
        while (p < 5 || ticks_sent - first_random < RANDOM_TICKS || ops_run < MIN_OPS) begin
            case (p)
                0: reconfigure(24'hFF_FFFF, 8'd1, GAIN_RESET);
                1: reconfigure(24'd1, 8'd2, 32'h7FFF_FFFF);
                2: reconfigure(24'd5, 8'd0, 32'h8000_0000);
                3: reconfigure(24'($urandom_range(2, 30)), 8'($urandom_range(1, 4)), 32'd0);
                4: reconfigure(24'd100, 8'd7, $urandom);
                default: begin
                    r = $urandom;
                    t = $urandom_range(0, 1) ? 24'($urandom_range(1, 40)) : 24'($urandom);
                    c = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
                    g = $urandom_range(0, 1) ? $urandom : {{12{r[19]}}, r[19:0]};
                    reconfigure(t, c, g);
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if (p == 4) begin
                // one measure over a longer run of samples
                run_op(1'b0);
                idle_ticks(2);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    run_op($urandom_range(0, 2) == 0);
                    idle_ticks($urandom_range(0, 3));
                end
            end
            p++;
        end

        stop_stream();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("Sent %0d ticks under %0d register settings; %0d operations ended, %0d by timeout.",
                 ticks_sent, configs_used, done_count, timeout_count);
        if (fail_count == 0 && pending == 0) begin
            $display("load_cell_adc_reader test passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("load_cell_adc_reader test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/lcar_pkg.sv
hdl/lcar_calc.sv
hdl/load_cell_adc_reader.sv
verif/lcar_checker.sv
verif/testbench.sv
